/* design/rnsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rnsp_pkg;

  // Field widths
  localparam int unsigned DimW    = 13;
  localparam int unsigned IdxW    = 20;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned MaskW   = 32;
  localparam int unsigned NumW    = CoordW + DimW;   // scaled coordinate numerator
  localparam int unsigned FacW    = 25;              // mask / 255
  localparam int unsigned ShW     = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 72;
  localparam int unsigned NumChan = 3;

  localparam int unsigned SourceDepth = 1048576;
  localparam int unsigned QueueDepth  = 4;

  // Channel rescale constants
  localparam int unsigned ChanMax    = 255;
  localparam int unsigned ChanRound  = 127;
  localparam logic [31:0] Recip255   = 32'h8080_8081;
  localparam int unsigned RecipShift = 39;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTgtWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTgtHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRotation  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRedMask   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGreenMask = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBlueMask  = 3'd7;

  // Operation codes
  localparam logic OpStore   = 1'b0;
  localparam logic OpRequest = 1'b1;

  // Item tag carried through the back pipeline
  typedef struct packed {
    logic            op;
    logic [IdxW-1:0] idx;
    logic [PixW-1:0] rgb;
  } tag_t;

  // Classified queue entry
  typedef struct packed {
    tag_t            tag;
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
  } item_t;

  // Active configuration, sizes already forced nonzero
  typedef struct packed {
    logic [DimW-1:0]                   sw;
    logic [DimW-1:0]                   sh;
    logic [DimW-1:0]                   tw;
    logic [DimW-1:0]                   th;
    logic [1:0]                        rot;
    logic [NumChan-1:0][FacW-1:0]      fa;
    logic [NumChan-1:0][ChanW-1:0]     fb;
    logic [NumChan-1:0][ShW-1:0]       fs;
  } cfg_t;

  function automatic logic [DimW-1:0] nonzero(input logic [DimW-1:0] v);
    nonzero = (v == '0) ? DimW'(1) : v;
  endfunction

endpackage

`default_nettype wire

/* design/rnsp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rnsp_front import rnsp_pkg::*; (
  input  wire cfg_t                 cfg_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  input  wire logic                 s_axis_tuser_i,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output item_t                     q_item_o
);

  logic [CoordW-1:0] x, y;
  logic [DimW-1:0]   dw, dh;

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // Unpack and take the rotated display size
  assign x  = s_axis_tdata_i[55:44];
  assign y  = s_axis_tdata_i[67:56];
  assign dw = cfg_i.rot[0] ? cfg_i.sh : cfg_i.sw;
  assign dh = cfg_i.rot[0] ? cfg_i.sw : cfg_i.sh;

  // Classify and form the scale numerators
  always_comb begin
    q_item_o.tag.op  = s_axis_tuser_i;
    q_item_o.tag.idx = s_axis_tdata_i[19:0];
    q_item_o.tag.rgb = {s_axis_tdata_i[27:20], s_axis_tdata_i[35:28], s_axis_tdata_i[43:36]};
    q_item_o.num_x   = NumW'({{DimW{1'b0}}, x} * {{CoordW{1'b0}}, dw});
    q_item_o.num_y   = NumW'({{DimW{1'b0}}, y} * {{CoordW{1'b0}}, dh});
  end

endmodule

`default_nettype wire

/* design/rnsp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module rnsp_queue import rnsp_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             store_q [DEPTH];
  logic [PW-1:0]     wptr_q, rptr_q;
  logic [PW:0]       cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = store_q[rptr_q];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= bump(wptr_q);
      if (pop_i)  rptr_q <= bump(rptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wptr_q] <= item_i;
  end

endmodule

`default_nettype wire

/* design/rnsp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rnsp_back import rnsp_pkg::*; #(
  parameter int unsigned SOURCE_DEPTH = SourceDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          q_valid_i,
  input  wire item_t         q_item_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [MaskW-1:0]   m_axis_tdata_o
);

  localparam int unsigned AW    = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
  localparam int unsigned AddrW = 2 * DimW + 1;
  localparam int unsigned NS    = NumW;
  localparam int unsigned PaW   = FacW + ChanW;
  localparam int unsigned TW    = 2 * ChanW;

  logic adv;
  logic out_vld_q;
  logic [MaskW-1:0] out_q;

  // Whole pipe moves whenever the output register can take a result
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign q_pop_o         = adv && q_valid_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // ---------------------------------------------------------------
  // Restoring dividers, one quotient bit per stage, x and y lanes
  logic            dv_vld_q [NS];
  tag_t            dv_tag_q [NS];
  logic [NumW-1:0] nx_q [NS], ny_q [NS], qx_q [NS], qy_q [NS];
  logic [DimW-1:0] rx_q [NS], ry_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic            vin;
    tag_t            tin;
    logic [NumW-1:0] nxin, nyin, qxin, qyin;
    logic [DimW-1:0] rxin, ryin;
    logic [DimW:0]   shx, shy;
    logic            gex, gey;

    if (k == 0) begin : g_head
      assign vin  = q_valid_i;
      assign tin  = q_item_i.tag;
      assign nxin = q_item_i.num_x;
      assign nyin = q_item_i.num_y;
      assign qxin = '0;
      assign qyin = '0;
      assign rxin = '0;
      assign ryin = '0;
    end else begin : g_body
      assign vin  = dv_vld_q[k-1];
      assign tin  = dv_tag_q[k-1];
      assign nxin = nx_q[k-1];
      assign nyin = ny_q[k-1];
      assign qxin = qx_q[k-1];
      assign qyin = qy_q[k-1];
      assign rxin = rx_q[k-1];
      assign ryin = ry_q[k-1];
    end

    assign shx = {rxin, nxin[NumW-1-k]};
    assign shy = {ryin, nyin[NumW-1-k]};
    assign gex = (shx >= {1'b0, cfg_i.tw});
    assign gey = (shy >= {1'b0, cfg_i.th});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_tag_q[k] <= tin;
        nx_q[k]     <= nxin;
        ny_q[k]     <= nyin;
        rx_q[k]     <= gex ? DimW'(shx - {1'b0, cfg_i.tw}) : shx[DimW-1:0];
        ry_q[k]     <= gey ? DimW'(shy - {1'b0, cfg_i.th}) : shy[DimW-1:0];
        qx_q[k]     <= {qxin[NumW-2:0], gex};
        qy_q[k]     <= {qyin[NumW-2:0], gey};
      end
    end
  end

  // ---------------------------------------------------------------
  // Clamp to the display size and map back through the rotation.
  // The mapped point always lands inside the source, so no second clamp.
  logic [DimW-1:0] dw, dh, dwm1, dhm1, dx, dy, sx, sy;
  logic            r_vld_q;
  tag_t            r_tag_q;
  logic [DimW-1:0] sx_q, sy_q;

  assign dw   = cfg_i.rot[0] ? cfg_i.sh : cfg_i.sw;
  assign dh   = cfg_i.rot[0] ? cfg_i.sw : cfg_i.sh;
  assign dwm1 = dw - DimW'(1);
  assign dhm1 = dh - DimW'(1);
  assign dx   = (qx_q[NS-1] > NumW'(dwm1)) ? dwm1 : qx_q[NS-1][DimW-1:0];
  assign dy   = (qy_q[NS-1] > NumW'(dhm1)) ? dhm1 : qy_q[NS-1][DimW-1:0];

  always_comb begin
    unique case (cfg_i.rot)
      2'd1: begin
        sx = dy;
        sy = cfg_i.sh - DimW'(1) - dx;
      end
      2'd2: begin
        sx = cfg_i.sw - DimW'(1) - dx;
        sy = cfg_i.sh - DimW'(1) - dy;
      end
      2'd3: begin
        sx = cfg_i.sw - DimW'(1) - dy;
        sy = dx;
      end
      default: begin
        sx = dx;
        sy = dy;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r_vld_q <= 1'b0;
    else if (adv) r_vld_q <= dv_vld_q[NS-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_tag_q <= dv_tag_q[NS-1];
      sx_q    <= sx;
      sy_q    <= sy;
    end
  end

  // ---------------------------------------------------------------
  // Linear source address
  logic             a_vld_q;
  tag_t             a_tag_q;
  logic [AddrW-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (adv) a_vld_q <= r_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_tag_q <= r_tag_q;
      addr_q  <= AddrW'({{(DimW+1){1'b0}}, sy_q} * {{(DimW+1){1'b0}}, cfg_i.sw})
               + AddrW'(sx_q);
    end
  end

  // ---------------------------------------------------------------
  // Frame store: stores write and requests fetch in item order
  logic [PixW-1:0] mem [SOURCE_DEPTH];
  logic            wr_en, rd_rng;
  logic            m_vld_q, m_op_q, m_rng_q;
  logic [PixW-1:0] rd_q;

  assign wr_en  = adv && a_vld_q && (a_tag_q.op == OpStore)
               && (32'(a_tag_q.idx) < 32'(SOURCE_DEPTH));
  assign rd_rng = (32'(addr_q) < 32'(SOURCE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AW'(a_tag_q.idx)] <= a_tag_q.rgb;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q    <= mem[AW'(addr_q)];
      m_op_q  <= a_tag_q.op;
      m_rng_q <= rd_rng;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (adv) m_vld_q <= a_vld_q;
  end

  // ---------------------------------------------------------------
  // Channel rescale, first half: v*(m/255) and the small remainder term
  logic [PixW-1:0] pix;
  logic            p_vld_q;
  logic [PaW-1:0]  pa_q [NumChan];
  logic [TW-1:0]   t_q  [NumChan];

  assign pix = m_rng_q ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else if (adv) p_vld_q <= m_vld_q && (m_op_q == OpRequest);
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_p1
    logic [ChanW-1:0] v;
    assign v = pix[PixW-1-ChanW*c -: ChanW];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pa_q[c] <= PaW'({{FacW{1'b0}}, v} * {{ChanW{1'b0}}, cfg_i.fa[c]});
        t_q[c]  <= TW'({{ChanW{1'b0}}, v} * {{ChanW{1'b0}}, cfg_i.fb[c]})
                 + TW'(ChanRound);
      end
    end
  end

  // ---------------------------------------------------------------
  // Second half: t/255 (exact for t below 65535), shift into place, merge
  logic [MaskW-1:0] part [NumChan];

  for (genvar c = 0; c < NumChan; c++) begin : g_p2
    logic [TW:0]    tsum;
    logic [PaW-1:0] qv, qs;
    assign tsum    = {1'b0, t_q[c]} + (TW+1)'(t_q[c] >> ChanW) + (TW+1)'(1);
    assign qv      = pa_q[c] + PaW'(tsum >> ChanW);
    assign qs      = qv << cfg_i.fs[c];
    assign part[c] = qs[MaskW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= p_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= part[0] | part[1] | part[2];
  end

endmodule

`default_nettype wire

/* design/rotating_nearest_scaler_packer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Rotating nearest-neighbor scaler with mask packing. A store transaction
// (tuser = 0) writes one RGB pixel into the on-chip frame store; a request
// transaction (tuser = 1) names an output coordinate and returns one packed
// pixel, stores return nothing. While the output is not stalled, the block
// takes one transaction per clock and gives one result per clock. A request
// passes the queue, the 25-stage divider that scales the coordinate, then the
// rotation, address, frame store, rescale and output registers. A small queue
// between the input side and the pipeline keeps the input ready while the
// output is stalled, until its four entries fill. Registers must be written
// only while the block is idle; the block itself does not enforce this. Mask
// changes take effect through the mask, shift and factor registers in turn.
module rotating_nearest_scaler_packer_unit import rnsp_pkg::*; #(
  parameter int unsigned SOURCE_DEPTH = SourceDepth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [MaskW-1:0]     cfg_wdata_i,
  // Input stream
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // source_index[19:0], red[27:20], green[35:28], blue[43:36],
  // out_x[55:44], out_y[67:56], zero pad[71:68]
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  // operation[0]
  input  wire logic                 s_axis_tuser_i,
  // Output stream
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // packed_pixel[31:0]
  output logic [MaskW-1:0]          m_axis_tdata_o
);

  logic [DimW-1:0]  src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [1:0]       rot_q;
  logic [MaskW-1:0] mask_q [NumChan];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= DimW'(640);
      src_h_q   <= DimW'(360);
      tgt_w_q   <= DimW'(640);
      tgt_h_q   <= DimW'(360);
      rot_q     <= '0;
      mask_q[0] <= 32'h00FF_0000;
      mask_q[1] <= 32'h0000_FF00;
      mask_q[2] <= 32'h0000_00FF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSrcWidth:  src_w_q   <= cfg_wdata_i[DimW-1:0];
        RegSrcHeight: src_h_q   <= cfg_wdata_i[DimW-1:0];
        RegTgtWidth:  tgt_w_q   <= cfg_wdata_i[DimW-1:0];
        RegTgtHeight: tgt_h_q   <= cfg_wdata_i[DimW-1:0];
        RegRotation:  rot_q     <= cfg_wdata_i[1:0];
        RegRedMask:   mask_q[0] <= cfg_wdata_i;
        RegGreenMask: mask_q[1] <= cfg_wdata_i;
        RegBlueMask:  mask_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Mask preprocessing: lowest set bit, then split m into 255*a + b
  logic [ShW-1:0]   tz_q [NumChan];
  logic [MaskW-1:0] mn_q [NumChan];
  logic [FacW-1:0]  fa_q [NumChan];
  logic [ChanW-1:0] fb_q [NumChan];

  for (genvar c = 0; c < NumChan; c++) begin : g_mask
    logic [ShW-1:0]   tz_d;
    logic [63:0]      prod;
    logic [FacW-1:0]  fa_d;
    logic [MaskW-1:0] rem;

    always_comb begin
      tz_d = '0;
      for (int i = MaskW - 1; i >= 0; i--) begin
        if (mask_q[c][i]) tz_d = ShW'(i);
      end
    end

    assign prod = {32'b0, mn_q[c]} * {32'b0, Recip255};
    assign fa_d = prod[RecipShift +: FacW];
    assign rem  = mn_q[c] - MaskW'({7'b0, fa_d} * 32'(ChanMax));

    always_ff @(posedge clk_i) begin
      tz_q[c] <= tz_d;
      mn_q[c] <= mask_q[c] >> tz_d;
      fa_q[c] <= fa_d;
      fb_q[c] <= rem[ChanW-1:0];
    end
  end

  cfg_t cfg;

  always_comb begin
    cfg.sw  = nonzero(src_w_q);
    cfg.sh  = nonzero(src_h_q);
    cfg.tw  = nonzero(tgt_w_q);
    cfg.th  = nonzero(tgt_h_q);
    cfg.rot = rot_q;
    for (int c = 0; c < NumChan; c++) begin
      cfg.fa[c] = fa_q[c];
      cfg.fb[c] = fb_q[c];
      cfg.fs[c] = tz_q[c];
    end
  end

  // Front, queue, back
  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_out;

  rnsp_front u_front (
    .cfg_i           (cfg),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  rnsp_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  rnsp_back #(
    .SOURCE_DEPTH (SOURCE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

/* design/rnsp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rnsp_checker import rnsp_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tready_o,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [MaskW-1:0] m_axis_tdata_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output result dropped or changed while stalled");

  // Pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // Queue comes out of reset with room
  a_rst_ready: assert property (@(posedge clk_i) !rst_ni |=> s_axis_tready_o)
    else $error("input not ready right after reset");

endmodule

bind rotating_nearest_scaler_packer_unit rnsp_checker u_rnsp_checker (.*);

`default_nettype wire
